[rtl/core/fpmd_pkg.sv]
// ----------------------------------------------------------------------------
// fpmd_pkg
// Shared commands, constants and the sideband carried along the divide chain.
// ----------------------------------------------------------------------------
package fpmd_pkg;

    localparam logic [2:0] CMD_MULDIV = 3'd0;
    localparam logic [2:0] CMD_FRAC16 = 3'd1;
    localparam logic [2:0] CMD_FRAC32 = 3'd2;
    localparam logic [2:0] CMD_DIV16  = 3'd3;
    localparam logic [2:0] CMD_PCT16  = 3'd4;
    localparam logic [2:0] CMD_PCT32  = 3'd5;

    localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [15:0] FULL16    = 16'hFFFF;
    localparam logic [47:0] HALF_BIAS = 48'h8000;
    localparam int          DIV_STEPS = 32;

    // control and side results that ride with a word through the cells
    typedef struct packed {
        logic [2:0]  cmd;
        logic        neg;     // muldiv: result is negated
        logic        sat;     // muldiv: saturate before sign
        logic        fixed;   // div16/pct: result is a constant
        logic [15:0] fix_val;
        logic [31:0] direct;  // frac16/frac32 result
    } t_side;

endpackage

[rtl/core/fpmd_if.sv]
// ----------------------------------------------------------------------------
// fpmd_in_if / fpmd_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface fpmd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;

    modport source (output valid, cmd, operand_a, operand_b, operand_c, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, operand_c, output ready);
endinterface

interface fpmd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [15:0] remainder_fraction;
    logic        divide_by_zero;

    modport source (output valid, result_value, remainder_fraction, divide_by_zero,
                    input ready);
    modport sink   (input valid, result_value, remainder_fraction, divide_by_zero,
                    output ready);
endinterface

[rtl/core/fixed_point_muldiv_unit_top.sv]
// ----------------------------------------------------------------------------
// fixed_point_muldiv_unit_top
// Six-operation fixed-point unit built around a multiplier and a divide chain.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while the output register is not held,
// and returns one result word per request, in order. A request passes
// through 36 register stages: operand prep, a 32x32 multiply, divide setup,
// a chain of 32 one-bit divide cells, and the output register.
// Every command goes through the same pipeline. The whole pipeline holds
// while a result sits in the output register and is not taken.
module fixed_point_muldiv_unit_top (
    input  logic i_clk,
    input  logic i_rst_n,
    fpmd_in_if.sink   i_in,
    fpmd_out_if.source o_out
);
    import fpmd_pkg::*;

    logic w_en;

    // ---- stage 1: operand prep ----
    logic        r1_vld;
    logic [2:0]  r1_cmd;
    logic        r1_neg, r1_fixed;
    logic [15:0] r1_fixv;
    logic [31:0] r1_mx, r1_my, r1_dvd, r1_dvs;

    logic [2:0]  n1_cmd;
    logic        n1_neg, n1_fixed;
    logic [15:0] n1_fixv;
    logic [31:0] n1_mx, n1_my, n1_dvd, n1_dvs;
    logic [31:0] w_a, w_b, w_c, w_ma, w_mb, w_mc, w_as, w_bs, w_fac;
    logic [15:0] w_a16, w_b16;
    logic [4:0]  w_shamt;
    logic        w_any;

    always_comb begin
        w_a   = i_in.operand_a;
        w_b   = i_in.operand_b;
        w_c   = i_in.operand_c;
        w_a16 = w_a[15:0];
        w_b16 = w_b[15:0];
        w_ma  = w_a[31] ? (32'd0 - w_a) : w_a;
        w_mb  = w_b[31] ? (32'd0 - w_b) : w_b;
        w_mc  = w_c[31] ? (32'd0 - w_c) : w_c;
        // full factor passes the value through: multiply by 1.0 in Q16
        w_fac = (w_b16 == FULL16) ? 32'h0001_0000 : {16'd0, w_b16};
        // pct32 shift: bits of b above bit 15
        w_shamt = 5'd0;
        w_any   = 1'b0;
        for (int i = 31; i >= 16; i--) begin
            w_any   = w_any | w_b[i];
            w_shamt = w_shamt + {4'd0, w_any};
        end
        w_as = w_a >> w_shamt;
        w_bs = w_b >> w_shamt;

        n1_cmd   = i_in.cmd;
        n1_neg   = 1'b0;
        n1_fixed = 1'b0;
        n1_fixv  = 16'd0;
        n1_mx    = 32'd0;
        n1_my    = 32'd0;
        n1_dvd   = 32'd0;
        n1_dvs   = 32'd0;
        case (i_in.cmd)
            CMD_MULDIV: begin
                n1_neg = w_a[31] ^ w_b[31] ^ w_c[31];
                n1_mx  = w_ma;
                n1_my  = w_mb;
                n1_dvs = w_mc;
            end
            CMD_FRAC16: begin
                n1_mx = {16'd0, w_a16};
                n1_my = w_fac;
            end
            CMD_FRAC32: begin
                n1_mx = w_a;
                n1_my = w_fac;
            end
            CMD_DIV16: begin
                n1_dvd   = {w_a16, 16'd0};
                n1_dvs   = {16'd0, w_b16};
                n1_fixed = (w_b16 == 16'd0);
            end
            CMD_PCT16: begin
                n1_dvd = {w_a16, 16'd0};
                n1_dvs = {16'd0, w_b16};
                if (w_a16 == w_b16) begin
                    n1_fixed = 1'b1;
                    n1_fixv  = FULL16;
                end else if (w_b16 == 16'd0) begin
                    n1_fixed = 1'b1;
                end else if (w_a16 >= w_b16) begin
                    n1_fixed = 1'b1;
                    n1_fixv  = FULL16;
                end
            end
            CMD_PCT32: begin
                n1_dvd = {w_as[15:0], 16'd0};
                n1_dvs = w_bs;
                if (w_a >= w_b || w_b == 32'd0) begin
                    n1_fixed = 1'b1;
                    n1_fixv  = FULL16;
                end
            end
            default: begin
                n1_fixed = 1'b1;
            end
        endcase
    end

    // ---- stage 2: multiply ----
    logic        r2_vld;
    logic [2:0]  r2_cmd;
    logic        r2_neg, r2_fixed;
    logic [15:0] r2_fixv;
    logic [31:0] r2_dvd, r2_dvs;
    logic [63:0] r2_prod;

    // ---- stage 3: divide setup ----
    logic [47:0] w_round;
    t_side       n3_side;
    logic [63:0] n3_acc;

    always_comb begin
        w_round          = r2_prod[47:0] + HALF_BIAS;
        n3_side.cmd      = r2_cmd;
        n3_side.neg      = r2_neg;
        n3_side.sat      = (r2_prod[63:32] >= r2_dvs);
        n3_side.fixed    = r2_fixed;
        n3_side.fix_val  = r2_fixv;
        n3_side.direct   = w_round[47:16];
        n3_acc = (r2_cmd == CMD_MULDIV) ? r2_prod : {32'd0, r2_dvd};
    end

    // divide chain wiring
    logic        w_vld  [0:DIV_STEPS];
    logic [63:0] w_acc  [0:DIV_STEPS];
    logic [31:0] w_dvs  [0:DIV_STEPS];
    t_side       w_side [0:DIV_STEPS];

    logic        r3_vld;
    logic [63:0] r3_acc;
    logic [31:0] r3_dvs;
    t_side       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd   <= n1_cmd;
            r1_neg   <= n1_neg;
            r1_fixed <= n1_fixed;
            r1_fixv  <= n1_fixv;
            r1_mx    <= n1_mx;
            r1_my    <= n1_my;
            r1_dvd   <= n1_dvd;
            r1_dvs   <= n1_dvs;

            r2_cmd   <= r1_cmd;
            r2_neg   <= r1_neg;
            r2_fixed <= r1_fixed;
            r2_fixv  <= r1_fixv;
            r2_dvd   <= r1_dvd;
            r2_dvs   <= r1_dvs;
            r2_prod  <= r1_mx * r1_my;

            r3_acc   <= n3_acc;
            r3_dvs   <= r2_dvs;
            r3_side  <= n3_side;
        end
    end

    assign w_vld[0]  = r3_vld;
    assign w_acc[0]  = r3_acc;
    assign w_dvs[0]  = r3_dvs;
    assign w_side[0] = r3_side;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        fpmd_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vld[g]),
            .i_acc  (w_acc[g]),
            .i_dvs  (w_dvs[g]),
            .i_side (w_side[g]),
            .o_vld  (w_vld[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_dvs  (w_dvs[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // ---- result formatting ----
    t_side       w_fs;
    logic [31:0] w_q, w_mag;
    logic [31:0] n_res;
    logic [15:0] n_frac;
    logic        n_dz;

    always_comb begin
        w_fs   = w_side[DIV_STEPS];
        w_q    = w_acc[DIV_STEPS][31:0];
        w_mag  = (w_fs.sat || w_q[31]) ? SAT_MAX : w_q;
        n_res  = 32'd0;
        n_frac = 16'd0;
        n_dz   = 1'b0;
        case (w_fs.cmd)
            CMD_MULDIV: n_res = w_fs.neg ? (32'd0 - w_mag) : w_mag;
            CMD_FRAC16: n_res = {16'd0, w_fs.direct[15:0]};
            CMD_FRAC32: n_res = w_fs.direct;
            CMD_DIV16: begin
                if (w_fs.fixed) begin
                    n_dz = 1'b1;
                end else begin
                    n_res  = {16'd0, w_q[31:16]};
                    n_frac = w_q[15:0];
                end
            end
            CMD_PCT16, CMD_PCT32: begin
                n_res = {16'd0, (w_fs.fixed ? w_fs.fix_val : w_q[15:0])};
            end
            default: n_res = 32'd0;
        endcase
    end

    // ---- output register ----
    logic        r_out_vld;
    logic [31:0] r_res;
    logic [15:0] r_frac;
    logic        r_dz;

    assign w_en = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res  <= n_res;
            r_frac <= n_frac;
            r_dz   <= n_dz;
        end
    end

    assign i_in.ready               = w_en;
    assign o_out.valid              = r_out_vld;
    assign o_out.result_value       = r_res;
    assign o_out.remainder_fraction = r_frac;
    assign o_out.divide_by_zero     = r_dz;

endmodule

[rtl/core/fpmd_div_cell.sv]
// ----------------------------------------------------------------------------
// fpmd_div_cell
// One restoring divide step: shifts the 64-bit remainder/quotient word left
// by one, subtracts the divisor when it fits, and passes everything on.
// ----------------------------------------------------------------------------
module fpmd_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [63:0]          i_acc,
    input  logic [31:0]          i_dvs,
    input  fpmd_pkg::t_side      i_side,
    output logic                 o_vld,
    output logic [63:0]          o_acc,
    output logic [31:0]          o_dvs,
    output fpmd_pkg::t_side      o_side
);
    import fpmd_pkg::*;

    logic        r_vld;
    logic [63:0] r_acc;
    logic [31:0] r_dvs;
    t_side       r_side;
    logic [63:0] n_acc;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_trial = {i_acc[63:32], i_acc[31]};
        w_diff  = w_trial - {1'b0, i_dvs};
        w_ge    = (w_trial >= {1'b0, i_dvs});
        n_acc   = {(w_ge ? w_diff[31:0] : w_trial[31:0]), i_acc[30:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_dvs  <= i_dvs;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_acc  = r_acc;
    assign o_dvs  = r_dvs;
    assign o_side = r_side;

endmodule
